### rtl/blw_pkg.sv
// ----------------------------------------------------------------------------
// blw_pkg
// shared types and constants for the bounded line walk counter
// ----------------------------------------------------------------------------
package blw_pkg;

    localparam int MAX_POSITIONS_DEF = 64;
    localparam int MAX_STEPS_DEF     = 1023;

    localparam int POS_W   = 7;    // line length and position fields
    localparam int STEP_W  = 10;   // step count field
    localparam int COUNT_W = 31;   // walk count field

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_INIT,
        S_STEP,
        S_DRAIN,
        S_READ,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic ld;        // capture query fields, clear counters
        logic init_wr;   // write one entry of the zero-step row
        logic step_rd;   // read both neighbors of the current index
        logic idx_inc;
        logic idx_clr;
        logic step_inc;  // one step finished
        logic row_flip;  // newest row moves to the other half
        logic final_rd;  // read the answer at the start position
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic bad;        // query out of range
        logic idx_last;   // index at the last position
        logic zero_steps;
        logic last_step;  // step being finished is the final one
    } t_sts;

endpackage

### rtl/blw_ctrl.sv
// ----------------------------------------------------------------------------
// blw_ctrl
// sequencer for the row fill, step loop and final read
// ----------------------------------------------------------------------------
module blw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  blw_pkg::t_sts i_sts,
    output blw_pkg::t_ctl o_ctl,
    output logic          o_busy,
    output logic          o_done
);
    import blw_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = i_sts.bad ? S_DONE : S_INIT;
            end
            S_INIT: begin
                if (i_sts.idx_last) n_state = i_sts.zero_steps ? S_READ : S_STEP;
            end
            S_STEP: begin
                if (i_sts.idx_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = i_sts.last_step ? S_READ : S_STEP;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_ctl  = '0;
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy   = 1'b0;
                o_ctl.ld = i_start;
            end
            S_CHECK: begin
            end
            S_INIT: begin
                o_ctl.init_wr = 1'b1;
                o_ctl.idx_inc = !i_sts.idx_last;
                o_ctl.idx_clr = i_sts.idx_last;
            end
            S_STEP: begin
                o_ctl.step_rd = 1'b1;
                o_ctl.idx_inc = !i_sts.idx_last;
                o_ctl.idx_clr = i_sts.idx_last;
            end
            S_DRAIN: begin
                o_ctl.step_inc = 1'b1;
                o_ctl.row_flip = 1'b1;
            end
            S_READ: begin
                o_ctl.final_rd = 1'b1;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

### rtl/blw_datapath.sv
// ----------------------------------------------------------------------------
// blw_datapath
// two-row table memory, index and step counters, saturating adder
// ----------------------------------------------------------------------------
module blw_datapath #(
    parameter int MAX_POSITIONS = blw_pkg::MAX_POSITIONS_DEF,
    parameter int MAX_STEPS     = blw_pkg::MAX_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  blw_pkg::t_ctl                 i_ctl,
    output blw_pkg::t_sts                 o_sts,
    input  logic [blw_pkg::POS_W-1:0]     i_line_length,
    input  logic [blw_pkg::POS_W-1:0]     i_start_position,
    input  logic [blw_pkg::POS_W-1:0]     i_target_position,
    input  logic [blw_pkg::STEP_W-1:0]    i_step_count,
    output logic [blw_pkg::COUNT_W-1:0]   o_walk_count,
    output logic                          o_overflow,
    output logic                          o_query_error
);
    import blw_pkg::*;

    localparam int DEPTH = 2 * MAX_POSITIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (MAX_POSITIONS > 2) ? $clog2(MAX_POSITIONS) : 1;

    // query fields
    logic [POS_W-1:0]  r_len;
    logic [POS_W-1:0]  r_start_pos;
    logic [POS_W-1:0]  r_target_pos;
    logic [STEP_W-1:0] r_steps_req;

    logic [PW-1:0]     r_idx;
    logic [STEP_W-1:0] r_steps_done;
    logic              r_cur;        // row holding the newest counts

    logic [COUNT_W-1:0] r_mem [DEPTH];
    logic [COUNT_W-1:0] r_rd_a;
    logic [COUNT_W-1:0] r_rd_b;
    logic               r_use_a;
    logic               r_use_b;
    logic [PW-1:0]      r_wr_idx;
    logic               r_wr_pend;

    logic [PW-1:0]      last_idx;
    logic [PW-1:0]      target_idx;
    logic [PW-1:0]      start_idx;
    logic [PW-1:0]      left_idx;
    logic [PW-1:0]      right_idx;
    logic [PW-1:0]      rd_a_idx;
    logic               rd_a_row;
    logic [AW-1:0]      rd_a_addr;
    logic [AW-1:0]      rd_b_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    logic [COUNT_W-1:0] wr_data;
    logic [COUNT_W:0]   sum;
    logic               bad;

    function automatic logic [AW-1:0] row_addr(input logic row, input logic [PW-1:0] idx);
        row_addr = row ? (AW'(idx) + AW'(MAX_POSITIONS)) : AW'(idx);
    endfunction

    assign last_idx   = PW'(r_len - POS_W'(1));
    assign target_idx = PW'(r_target_pos - POS_W'(1));
    assign start_idx  = PW'(r_start_pos - POS_W'(1));

    assign bad = (r_len < POS_W'(2)) || (32'(r_len) > 32'(MAX_POSITIONS))
              || (r_start_pos == '0) || (r_start_pos > r_len)
              || (r_target_pos == '0) || (r_target_pos > r_len)
              || (32'(r_steps_req) > 32'(MAX_STEPS));

    assign o_sts.bad        = bad;
    assign o_sts.idx_last   = (r_idx == last_idx);
    assign o_sts.zero_steps = (r_steps_req == '0);
    assign o_sts.last_step  = ((STEP_W+1)'(r_steps_done) + (STEP_W+1)'(1))
                              == (STEP_W+1)'(r_steps_req);

    // neighbors, clamped in range at the ends (masked later)
    assign left_idx  = (r_idx == '0) ? r_idx : r_idx - PW'(1);
    assign right_idx = (r_idx == last_idx) ? r_idx : r_idx + PW'(1);

    assign rd_a_idx  = i_ctl.final_rd ? start_idx : left_idx;
    assign rd_a_row  = r_cur;
    assign rd_a_addr = row_addr(rd_a_row, rd_a_idx);
    assign rd_b_addr = row_addr(r_cur, right_idx);

    assign sum = (r_use_a ? {1'b0, r_rd_a} : '0) + (r_use_b ? {1'b0, r_rd_b} : '0);

    always_comb begin
        if (i_ctl.init_wr) begin
            wr_en   = 1'b1;
            wr_addr = row_addr(1'b0, r_idx);
            wr_data = (r_idx == target_idx) ? COUNT_W'(1) : '0;
        end else begin
            wr_en   = r_wr_pend;
            wr_addr = row_addr(!r_cur, r_wr_idx);
            wr_data = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
        end
    end

    // table memory: one write, two reads
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.step_rd || i_ctl.final_rd) begin
            r_rd_a <= r_mem[rd_a_addr];
        end
        if (i_ctl.step_rd) begin
            r_rd_b <= r_mem[rd_b_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_len        <= i_line_length;
            r_start_pos  <= i_start_position;
            r_target_pos <= i_target_position;
            r_steps_req  <= i_step_count;
        end
        if (i_ctl.step_rd) begin
            r_use_a  <= (r_idx != '0);
            r_use_b  <= (r_idx != last_idx);
            r_wr_idx <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx        <= '0;
            r_steps_done <= '0;
            r_cur        <= 1'b0;
            r_wr_pend    <= 1'b0;
        end else begin
            r_wr_pend <= i_ctl.step_rd;
            if (i_ctl.ld || i_ctl.idx_clr) begin
                r_idx <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + PW'(1);
            end
            if (i_ctl.ld) begin
                r_steps_done <= '0;
                r_cur        <= 1'b0;
            end else begin
                if (i_ctl.step_inc) r_steps_done <= r_steps_done + STEP_W'(1);
                if (i_ctl.row_flip) r_cur <= !r_cur;
            end
        end
    end

    assign o_walk_count  = bad ? '0 : r_rd_a;
    assign o_overflow    = !bad && (r_rd_a == COUNT_MAX);
    assign o_query_error = bad;

endmodule

### rtl/bounded_line_walk_counter.sv
// ----------------------------------------------------------------------------
// bounded_line_walk_counter
// counts walks on a bounded line that end on a target after an exact number
// of unit steps, by filling a two-row table one step at a time
// ----------------------------------------------------------------------------
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+--------------------------------------
//  query    | start in, busy out          | i_line_length, i_start_position,
//           | beat when start && !busy    | i_target_position, i_step_count
//  result   | o_result_valid, one cycle   | o_walk_count, o_overflow,
//           | beat at end of that cycle   | o_query_error
//
//  sequence: with n = line length and s = step count, a valid query passes
//  through the check state, the n-entry row init, s steps and the final read
//  before the result cycle; each step walks the shared adder across n entries,
//  then a drain state retires the last write through the registered memory read
//  an invalid query goes from the check state straight to its error beat
//  reset: synchronous, active low; the table memory is not cleared, every
//  entry of a row is written before the row is read
//  the receiver cannot stall; busy stays high through the result cycle
//
module bounded_line_walk_counter #(
    parameter int MAX_POSITIONS = blw_pkg::MAX_POSITIONS_DEF,
    parameter int MAX_STEPS     = blw_pkg::MAX_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [blw_pkg::POS_W-1:0]     i_line_length,
    input  logic [blw_pkg::POS_W-1:0]     i_start_position,
    input  logic [blw_pkg::POS_W-1:0]     i_target_position,
    input  logic [blw_pkg::STEP_W-1:0]    i_step_count,
    output logic                          o_result_valid,
    output logic [blw_pkg::COUNT_W-1:0]   o_walk_count,
    output logic                          o_overflow,
    output logic                          o_query_error
);
    import blw_pkg::*;

    t_ctl ctl;   // commands to the datapath
    t_sts sts;   // status back to the sequencer

    // sequencer: row init, step loop, drain, final read, result beat
    blw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_result_valid)
    );

    // table memory, counters and saturating adder
    blw_datapath #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .MAX_STEPS     (MAX_STEPS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .i_line_length     (i_line_length),
        .i_start_position  (i_start_position),
        .i_target_position (i_target_position),
        .i_step_count      (i_step_count),
        .o_walk_count      (o_walk_count),
        .o_overflow        (o_overflow),
        .o_query_error     (o_query_error)
    );

endmodule

### rtl/blw_checker.sv
// ----------------------------------------------------------------------------
// blw_checker
// port-level checks for the bounded line walk counter
// ----------------------------------------------------------------------------
module blw_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [blw_pkg::POS_W-1:0]     i_line_length,
    input logic                          o_result_valid,
    input logic [blw_pkg::COUNT_W-1:0]   o_walk_count,
    input logic                          o_overflow,
    input logic                          o_query_error
);
    import blw_pkg::*;

    // a result beat only closes a query in progress
    a_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result beat while idle");

    // result strobe lasts one cycle
    a_beat_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    // too short a line is reported as an error beat once the check state has run
    a_short_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_line_length < POS_W'(2)))
            |=> ##1 (o_result_valid && o_query_error))
        else $error("short line not reported as error");

    // error beat carries a zero count and no overflow
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_query_error) |-> (o_walk_count == '0 && !o_overflow))
        else $error("error beat with nonzero count");

    // overflow only at the saturated count
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_overflow) |-> (o_walk_count == COUNT_MAX))
        else $error("overflow flag without saturated count");

endmodule

bind bounded_line_walk_counter blw_checker u_blw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_line_length  (i_line_length),
    .o_result_valid (o_result_valid),
    .o_walk_count   (o_walk_count),
    .o_overflow     (o_overflow),
    .o_query_error  (o_query_error)
);

### bench/tb_bounded_line_walk_counter.sv
// ----------------------------------------------------------------------------
// tb_bounded_line_walk_counter
// self-checking bench for the bounded line walk counter: queued queries go
// through a start/busy driver, every result beat is checked field by field
// against a two-row table predictor kept inside the bench
// ----------------------------------------------------------------------------
module tb_bounded_line_walk_counter;

    timeunit 1ns;
    timeprecision 1ps;

    import blw_pkg::*;

    localparam int MAX_POS        = MAX_POSITIONS_DEF;
    localparam int MAX_STEP_COUNT = MAX_STEPS_DEF;
    // slowest query is 64 positions by 1023 steps
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int SETTLE_CYCLES  = 8;

    // one query beat plus the idle cycles to leave before it
    typedef struct packed {
        logic [POS_W-1:0]  line_length;
        logic [POS_W-1:0]  start_pos;
        logic [POS_W-1:0]  target_pos;
        logic [STEP_W-1:0] step_count;
        logic [3:0]        gap_cycles;
    } t_walk_query;

    typedef struct packed {
        logic [COUNT_W-1:0] walk_count;
        logic               overflow;
        logic               query_error;
    } t_walk_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [POS_W-1:0]   i_line_length = '0;
    logic [POS_W-1:0]   i_start_position = '0;
    logic [POS_W-1:0]   i_target_position = '0;
    logic [STEP_W-1:0]  i_step_count = '0;
    logic               o_result_valid;
    logic [COUNT_W-1:0] o_walk_count;
    logic               o_overflow;
    logic               o_query_error;

    t_walk_query  query_queue[$];       // queries not yet driven
    t_walk_result expected_walks[$];    // predictions waiting for their beat

    // bench copy of the two-row table, rows selected by step parity
    logic [COUNT_W-1:0] walk_rows [2][MAX_POS];

    logic query_beat = 1'b0;            // query accepted at the last rising edge
    bit   gaps_enabled = 1'b1;          // sender idles in bursts while set
    int   idle_cycles = 0;
    int   mismatches = 0;
    int   queries_taken = 0;
    int   results_checked = 0;
    int   invalid_seen = 0;
    int   saturated_seen = 0;

    bounded_line_walk_counter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_line_length     (i_line_length),
        .i_start_position  (i_start_position),
        .i_target_position (i_target_position),
        .i_step_count      (i_step_count),
        .o_result_valid    (o_result_valid),
        .o_walk_count      (o_walk_count),
        .o_overflow        (o_overflow),
        .o_query_error     (o_query_error)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // counts walks from src_pos that sit on dst_pos after exactly steps moves;
    // the row for step s holds, per position, the ways to reach the target in s moves
    function automatic t_walk_result predict_walks(
        input logic [POS_W-1:0]  len,
        input logic [POS_W-1:0]  src_pos,
        input logic [POS_W-1:0]  dst_pos,
        input logic [STEP_W-1:0] steps
    );
        t_walk_result     res;
        int               n;
        int               cur;
        int               prv;
        int               p;
        int               s;
        logic [COUNT_W:0] sum;
        res = '0;
        n = len;
        // bad query: error flag, zero count, table untouched
        if (n < 2 || n > MAX_POS || src_pos == 0 || src_pos > len ||
                dst_pos == 0 || dst_pos > len || steps > MAX_STEP_COUNT) begin
            res.query_error = 1'b1;
            return res;
        end
        for (p = 1; p <= n; p++) begin
            walk_rows[0][p-1] = (p == dst_pos) ? COUNT_W'(1) : '0;
        end
        cur = 0;
        for (s = 1; s <= steps; s++) begin
            prv = cur;
            cur = 1 - cur;
            for (p = 1; p <= n; p++) begin
                if (p == 1) begin
                    // left wall: only a right move
                    walk_rows[cur][0] = walk_rows[prv][1];
                end else if (p == n) begin
                    // right wall: only a left move
                    walk_rows[cur][n-1] = walk_rows[prv][n-2];
                end else begin
                    sum = {1'b0, walk_rows[prv][p-2]} + {1'b0, walk_rows[prv][p]};
                    // saturated entries stay pinned through later steps
                    walk_rows[cur][p-1] = (sum > COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
                end
            end
        end
        res.walk_count = walk_rows[cur][src_pos-1];
        // a true count of exactly the max also reads as saturated
        res.overflow = (res.walk_count == COUNT_MAX);
        return res;
    endfunction

    task automatic queue_query(
        input int len,
        input int src_pos,
        input int dst_pos,
        input int steps
    );
        t_walk_query q;
        q.line_length = POS_W'(len);
        q.start_pos   = POS_W'(src_pos);
        q.target_pos  = POS_W'(dst_pos);
        q.step_count  = STEP_W'(steps);
        q.gap_cycles  = (gaps_enabled && $urandom_range(0, 1) == 1) ?
                        4'($urandom_range(1, 14)) : 4'd0;
        query_queue.push_back(q);
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs move on the falling edge; a query is held with start
    // high until the beat, and the next one may be raised in the same edge
    // the previous beat is retired, so start never drops between back-to-back
    // queries; a gap only counts down once the block has gone free
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : query_driver
        t_walk_query nxt;
        int          hold_left;
        bit          gap_loaded;
        if (!i_rst_n) begin
            start      <= 1'b0;
            hold_left  = 0;
            gap_loaded = 1'b0;
        end else if (!start || query_beat) begin
            if (query_queue.size() == 0) begin
                start <= 1'b0;
            end else begin
                if (!gap_loaded) begin
                    hold_left  = query_queue[0].gap_cycles;
                    gap_loaded = 1'b1;
                end
                if (hold_left != 0) begin
                    start <= 1'b0;
                    if (!busy) begin
                        hold_left--;
                    end
                end else begin
                    nxt = query_queue.pop_front();
                    gap_loaded        = 1'b0;
                    i_line_length     <= nxt.line_length;
                    i_start_position  <= nxt.start_pos;
                    i_target_position <= nxt.target_pos;
                    i_step_count      <= nxt.step_count;
                    start             <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: sample on the rising edge; an accepted query beat pushes its
    // prediction, a result beat is matched against the oldest one
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_walk_result want;
        if (!i_rst_n) begin
            query_beat <= 1'b0;
        end else begin
            query_beat <= start && !busy;
            if (start && !busy) begin
                expected_walks.push_back(predict_walks(i_line_length, i_start_position,
                                                       i_target_position, i_step_count));
                queries_taken++;
            end
            if (o_result_valid) begin
                if (expected_walks.size() == 0) begin
                    $error("result beat with no query outstanding: count %0d ovf %0b err %0b",
                           o_walk_count, o_overflow, o_query_error);
                    mismatches++;
                end else begin
                    want = expected_walks.pop_front();
                    results_checked++;
                    if (want.query_error) invalid_seen++;
                    if (want.overflow) saturated_seen++;
                    if (o_walk_count !== want.walk_count) begin
                        $error("walk_count: expected %0d, actual %0d",
                               want.walk_count, o_walk_count);
                        mismatches++;
                    end
                    if (o_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b", want.overflow, o_overflow);
                        mismatches++;
                    end
                    if (o_query_error !== want.query_error) begin
                        $error("query_error: expected %0b, actual %0b",
                               want.query_error, o_query_error);
                        mismatches++;
                    end
                end
            end
            // watchdog only sees cycles with neither kind of beat
            if ((start && !busy) || o_result_valid) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $error("no beat for %0d cycles, giving up", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int k;
        int sel;
        int n;
        // bad queries: short or long line, zero or out-of-range positions
        queue_query(0, 1, 1, 5);
        queue_query(1, 1, 1, 3);
        queue_query(65, 1, 1, 2);
        queue_query(127, 127, 127, 1023);
        queue_query(64, 0, 5, 3);
        queue_query(64, 5, 0, 3);
        queue_query(10, 11, 3, 2);
        queue_query(10, 3, 11, 2);
        queue_query(64, 127, 1, 1);
        // zero steps: one walk only when start and target agree
        queue_query(5, 3, 3, 0);
        queue_query(5, 2, 4, 0);
        // two positions bounce forever, parity decides the count
        queue_query(2, 1, 2, 1023);
        queue_query(2, 1, 2, 1022);
        // wall to wall in the fewest steps, and near the right wall
        queue_query(64, 1, 64, 63);
        queue_query(64, 64, 64, 2);
        queue_query(10, 5, 6, 1);
        // three positions double every two steps: just under, then past the max
        queue_query(3, 2, 2, 60);
        queue_query(3, 2, 2, 62);
        // saturation in the middle, from a wall, and the longest query
        queue_query(64, 32, 32, 40);
        queue_query(64, 1, 1, 100);
        queue_query(64, 64, 1, 1023);

        for (k = 0; k < 100; k++) begin
            if (k % 12 == 0) gaps_enabled = ($urandom_range(0, 2) != 0);
            if (k >= 80) gaps_enabled = 1'b0;   // closing stretch runs flat out
            sel = $urandom_range(0, 99);
            if (sel < 10) begin
                // noise: raw field bits, mostly rejected
                queue_query($urandom_range(0, 127), $urandom_range(0, 127),
                            $urandom_range(0, 127), $urandom_range(0, 63));
            end else begin
                n = (sel < 93) ? $urandom_range(2, MAX_POS) : $urandom_range(2, 8);
                if (sel < 80) begin
                    queue_query(n, $urandom_range(1, n), $urandom_range(1, n),
                                $urandom_range(0, 40));
                end else if (sel < 93) begin
                    queue_query(n, $urandom_range(1, n), $urandom_range(1, n),
                                $urandom_range(41, 160));
                end else begin
                    // long walks on short lines keep the high step bits busy
                    queue_query(n, $urandom_range(1, n), $urandom_range(1, n),
                                $urandom_range(161, MAX_STEP_COUNT));
                end
            end
        end

        // synchronous reset, released on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (query_queue.size() != 0 || start) @(posedge i_clk);
        while (expected_walks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("ran %0d queries, %0d rejected as invalid, %0d saturated the count",
                 queries_taken, invalid_seen, saturated_seen);
        $display("checked %0d result beats, %0d field mismatches",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
